@@ rtl/core/fcw_pkg.sv @@
// Package for the cluster chain walker: table geometry, command and status codes.
// No dependencies; imported by fat_cluster_chain_walker_unit.
package fcw_pkg;
    localparam int unsigned TableEntries = 4096;
    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam int unsigned StepW = $clog2(TableEntries) + 1;
    localparam logic [27:0] EndMark = 28'h0FFFFFFF;
    localparam logic [27:0] FirstData = 28'd2;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0, CMD_NEXT = 3'd1, CMD_OFFSET = 3'd2, CMD_LAST = 3'd3,
        CMD_PREV = 3'd4, CMD_COUNT = 3'd5, CMD_ADDR = 3'd6, CMD_NONE = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_LOW = 2'd1, ST_END = 2'd2, ST_RANGE = 2'd3
    } t_status;

    localparam logic [1:0] CfgDataStart = 2'd0;
    localparam logic [1:0] CfgSpcLog2 = 2'd1;
    localparam logic [1:0] CfgBpsLog2 = 2'd2;
endpackage

@@ rtl/core/fat_cluster_chain_walker_unit.sv @@
// Cluster chain walker: allocation table memory and its command sequencer.
// Depends on fcw_pkg.
//
// Use: one command enters on the s_axis channel (tdata packs cmd, start_cluster,
// target_cluster, entry_value, byte_offset from bit 0 up) and exactly one result
// leaves on the m_axis channel. The user must write registers over the cfg channel
// only while the block is idle; the block itself does not enforce this.
// A write, a bad-argument command or an address command goes from the accepting
// edge straight to S_DONE, where its result is loaded. A walk passes S_READ and
// S_EVAL for each table read, since every link read from the table (a registered
// read) chooses the next address; a walk stopped by the walk limit ends in S_READ
// with ST_RANGE. The next command is taken the cycle after a result is loaded.
// After reset the table is cleared by a pass over all 4096 entries, one entry a
// cycle, during which s_axis_tready is low; cfg writes are taken throughout.
// One command is worked at a time. A finished result sits in the output register
// while the next command is accepted and worked; only that command's completion
// waits for the receiver to take the held result.
module fat_cluster_chain_walker_unit
    import fcw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // cmd[2:0], start_cluster[30:3], target_cluster[58:31], entry_value[90:59],
    // byte_offset[130:91], zero fill [135:131]
    input  logic [135:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result_cluster[31:0], chain_count[44:32], sector_address[76:45],
    // byte_address[120:77], status[122:121], zero fill [127:123]
    output logic [127:0]  m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DONE} t_state;

    logic [31:0] mem [TableEntries];
    logic [31:0] r_rdata;

    t_state       r_state;
    logic [IdxW:0] r_clr;
    t_cmd         r_cmd;
    logic [27:0]  r_cur, r_target;
    logic [39:0]  r_nlinks;
    logic [StepW-1:0] r_steps;
    logic [12:0]  r_cnt;
    t_status      r_st;
    logic [31:0]  r_res, r_sec;
    logic [43:0]  r_byt;
    logic         r_ovalid;
    logic [127:0] r_odata;

    logic [31:0] r_dss;
    logic [2:0]  r_spc;
    logic [3:0]  r_bps;

    logic [3:0]  w_bps_sat;
    logic [4:0]  w_sh;
    logic [27:0] w_link;
    logic        w_cur_in;
    logic        w_walk_ok;
    logic [31:0] w_sec;

    // Fields of the incoming transaction.
    t_cmd        w_icmd;
    logic [27:0] w_istart, w_itarget;
    logic [31:0] w_ivalue;
    logic [39:0] w_ioff;

    assign w_icmd    = t_cmd'(s_axis_tdata[2:0]);
    assign w_istart  = s_axis_tdata[30:3];
    assign w_itarget = s_axis_tdata[58:31];
    assign w_ivalue  = s_axis_tdata[90:59];
    assign w_ioff    = s_axis_tdata[130:91];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Sector size clamp and total shift.
    always_comb begin
        w_bps_sat = r_bps;
        if (r_bps < 4'd9) w_bps_sat = 4'd9;
        if (r_bps > 4'd12) w_bps_sat = 4'd12;
        w_sh = 5'(r_spc) + 5'(w_bps_sat);
    end

    // First sector of the incoming cluster; wraps at 32 bits.
    assign w_sec = r_dss + ({4'd0, w_istart - FirstData} << r_spc);

    assign w_link    = r_rdata[27:0];
    assign w_cur_in  = (r_cur < 28'(TableEntries));
    // A walk may read again while under the limit and inside the table.
    assign w_walk_ok = (r_steps < StepW'(TableEntries)) && w_cur_in;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dss <= '0;
            r_spc <= '0;
            r_bps <= 4'd9;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgDataStart: r_dss <= i_cfg_data;
                CfgSpcLog2:   r_spc <= i_cfg_data[2:0];
                CfgBpsLog2:   r_bps <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Table memory: one write port, shared by the clear pass and command writes; r_cur is read into a register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr[IdxW-1:0]] <= '0;
        end else if (s_axis_tvalid && s_axis_tready && w_icmd == CMD_WRITE
                     && w_istart < 28'(TableEntries)) begin
            mem[w_istart[IdxW-1:0]] <= w_ivalue;
        end
        r_rdata <= mem[r_cur[IdxW-1:0]];
    end

    // Command sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Load a finished result, or drop the held one once it is taken.
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (IdxW+1)'(TableEntries - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= w_icmd;
                        r_cur    <= w_istart;
                        r_target <= w_itarget;
                        r_nlinks <= w_ioff >> w_sh;
                        r_steps  <= '0;
                        r_cnt    <= '0;
                        r_st     <= ST_OK;
                        r_res    <= '0;
                        r_sec    <= '0;
                        r_byt    <= '0;
                        r_state  <= S_DONE;
                        if (w_icmd == CMD_WRITE) begin
                            if (w_istart >= 28'(TableEntries)) r_st <= ST_RANGE;
                        end else if (w_icmd == CMD_NONE) begin
                            r_st <= ST_RANGE;
                        end else if (w_istart < FirstData
                                || (w_icmd == CMD_PREV && w_itarget < FirstData)) begin
                            r_st <= ST_LOW;
                        end else if (w_icmd == CMD_ADDR) begin
                            r_sec <= w_sec;
                            r_byt <= {12'd0, w_sec} << w_bps_sat;
                        end else if (w_icmd == CMD_PREV && w_itarget == w_istart) begin
                            r_st <= ST_END;
                        end else if (w_icmd == CMD_NEXT) begin
                            if (w_istart >= 28'(TableEntries)) r_st <= ST_RANGE;
                            else r_state <= S_READ;
                        end else if (w_icmd == CMD_OFFSET) begin
                            if ((w_ioff >> w_sh) == 40'd0) r_res <= {4'd0, w_istart};
                            else r_state <= S_READ;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // Check a walk's read is allowed (not for CMD_NEXT); the address r_cur is in flight.
                    if (r_cmd != CMD_NEXT && !w_walk_ok) begin
                        r_st    <= ST_RANGE;
                        r_state <= S_DONE;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_DONE;
                    case (r_cmd)
                        CMD_NEXT: begin
                            if (w_link >= EndMark || w_link < FirstData) r_st <= ST_END;
                            else r_res <= {4'd0, w_link};
                        end
                        CMD_OFFSET: begin
                            if (w_link >= EndMark || w_link < FirstData) begin
                                r_st <= ST_END;
                            end else begin
                                r_cur <= w_link;
                                if (40'(r_steps) == r_nlinks) r_res <= {4'd0, w_link};
                                else r_state <= S_READ;
                            end
                        end
                        default: begin
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cmd == CMD_PREV && w_link == r_target) begin
                                r_res <= {4'd0, r_cur};
                            end else if (w_link >= EndMark) begin
                                if (r_cmd == CMD_LAST) r_res <= {4'd0, r_cur};
                                else if (r_cmd == CMD_PREV) r_st <= ST_END;
                            end else if (w_link < FirstData) begin
                                r_st <= ST_END;
                            end else begin
                                r_cur   <= w_link;
                                r_state <= S_READ;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state  <= S_IDLE;
                        if (r_st != ST_OK) begin
                            r_odata <= {5'd0, r_st, 121'd0};
                        end else begin
                            r_odata <= {5'd0, r_st, r_byt, r_sec,
                                        (r_cmd == CMD_COUNT) ? r_cnt : 13'd0, r_res};
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
